/* hw/rtl/clis_pkg.sv */
// Shared types, widths and helpers for the longest increasing subsequence counter.
`timescale 1ns / 1ps
`default_nettype none

package clis_pkg;

    localparam int VALUE_W  = 32;
    localparam int LEVEL_W  = 8;
    localparam int LENGTH_W = 9;
    localparam int COUNT_W  = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S1_RD,
        ST_S1_CMP,
        ST_LEN_RD,
        ST_LEN_WT,
        ST_PLEN_WT,
        ST_S2_RD,
        ST_S2_CMP,
        ST_SUM_WT,
        ST_LOW_WT,
        ST_BEF_RD,
        ST_BEF_WT,
        ST_WRITE,
        ST_DONE
    } state_t;

    function automatic logic s_less(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clis_in_if.sv */
// Input channel: one sequence element per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface clis_in_if;
    logic                         valid;
    logic                         ready;
    logic [clis_pkg::VALUE_W-1:0] value;
    logic                         last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

/* hw/rtl/clis_out_if.sv */
// Result channel: one result per accepted element.
`timescale 1ns / 1ps
`default_nettype none

interface clis_out_if;
    logic                          valid;
    logic                          ready;
    logic [clis_pkg::LEVEL_W-1:0]  level;
    logic [clis_pkg::COUNT_W-1:0]  ways_here;
    logic [clis_pkg::LENGTH_W-1:0] lis_length;
    logic [clis_pkg::COUNT_W-1:0]  lis_count;
    logic                          overflow;

    modport source (output valid, output level, output ways_here, output lis_length,
                    output lis_count, output overflow, input ready);
    modport sink (input valid, input level, input ways_here, input lis_length,
                  input lis_count, input overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/count_longest_increasing_subseq_top.sv */
// Longest strictly increasing subsequence counter: top level with search sequencer.
// Usage:
//   item   : one signed 32-bit element per transaction, last_item marks the end.
//   result : one transaction per element: level, ways_here, lis_length,
//            lis_count and the sticky overflow flag.
// One element at a time: the next element is accepted only once the result of
// the last one has been loaded. After the accept, an element runs a binary search
// over the piles and one in the previous pile, then the memory reads, the write
// and the result load. The search speed is set by the single read port of each
// memory: every search step is one read and one compare.
// Tails and pile lengths share one memory; entry values and prefix sums
// share another, laid out as pile * 2^ceil(log2(MAX_ITEMS)) + position.
// The result sits in an output register; a new element is accepted while it
// waits. A stalled result holds the sequencer in its last state.
// Reset clears the pile count, top count and overflow flag; memories need no
// clearing because only entries written in the current sequence are read.
// After last_item the same state is cleared once its result is loaded.
`timescale 1ns / 1ps
`default_nettype none

module count_longest_increasing_subseq_top #(
    parameter int MAX_ITEMS = 256
) (
    input wire logic clk,
    input wire logic rst_n,
    clis_in_if.sink    item,
    clis_out_if.source result
);

    localparam int LW  = $clog2(MAX_ITEMS);
    localparam int CW  = LW + 1;
    localparam int VW  = clis_pkg::VALUE_W;
    localparam int NW  = clis_pkg::COUNT_W;
    localparam int PW  = VW + CW;
    localparam int EW  = VW + NW;
    localparam int EDEPTH = 1 << (2 * LW);

    clis_pkg::state_t state_reg, state_next;

    logic [VW-1:0] v_reg, v_next;
    logic          last_reg, last_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] lvl_reg, lvl_next, cur_len_reg, cur_len_next, plen_reg, plen_next;
    logic [NW-1:0] ways_reg, ways_next, before_reg, before_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] pile_count_reg, pile_count_next;
    logic [NW-1:0] top_count_reg, top_count_next;
    logic          ovf_reg, ovf_next;

    logic                          res_valid_reg, res_valid_next;
    logic [clis_pkg::LEVEL_W-1:0]  res_level_reg, res_level_next;
    logic [NW-1:0]                 res_ways_reg, res_ways_next;
    logic [clis_pkg::LENGTH_W-1:0] res_len_reg, res_len_next;
    logic [NW-1:0]                 res_count_reg, res_count_next;
    logic                          res_ovf_reg, res_ovf_next;

    logic            pr_we, pr_re;
    logic [LW-1:0]   pr_waddr, pr_raddr;
    logic [PW-1:0]   pr_wdata, pr_rdata;
    logic            er_we, er_re;
    logic [2*LW-1:0] er_waddr, er_raddr;
    logic [EW-1:0]   er_wdata, er_rdata;

    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid_w, lvl_m1, len_now;
    logic [NW:0]     add_sum;
    logic            out_free;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w    = mid_sum[CW:1];
    assign lvl_m1   = lvl_reg - CW'(1);
    assign len_now  = (lvl_reg == pile_count_reg) ? '0 : pr_rdata[CW-1:0];
    assign add_sum  = {1'b0, before_reg} + {1'b0, ways_reg};
    assign out_free = !res_valid_reg || result.ready;

    clis_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_pile_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .re    (pr_re),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    clis_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (er_we),
        .waddr (er_waddr),
        .wdata (er_wdata),
        .re    (er_re),
        .raddr (er_raddr),
        .rdata (er_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clis_pkg::ST_IDLE:
                if (item.valid) state_next = clis_pkg::ST_S1_RD;
            clis_pkg::ST_S1_RD:
                state_next = (lo_reg < hi_reg) ? clis_pkg::ST_S1_CMP : clis_pkg::ST_LEN_RD;
            clis_pkg::ST_S1_CMP:
                state_next = clis_pkg::ST_S1_RD;
            clis_pkg::ST_LEN_RD:
                state_next = (lvl_reg == CW'(MAX_ITEMS)) ? clis_pkg::ST_DONE
                                                         : clis_pkg::ST_LEN_WT;
            clis_pkg::ST_LEN_WT:
                if (len_now >= CW'(MAX_ITEMS)) state_next = clis_pkg::ST_DONE;
                else if (lvl_reg == '0)        state_next = clis_pkg::ST_BEF_RD;
                else                           state_next = clis_pkg::ST_PLEN_WT;
            clis_pkg::ST_PLEN_WT:
                state_next = clis_pkg::ST_S2_RD;
            clis_pkg::ST_S2_RD:
                state_next = (lo_reg < hi_reg) ? clis_pkg::ST_S2_CMP : clis_pkg::ST_SUM_WT;
            clis_pkg::ST_S2_CMP:
                state_next = clis_pkg::ST_S2_RD;
            clis_pkg::ST_SUM_WT:
                state_next = (hi_reg == '0) ? clis_pkg::ST_BEF_RD : clis_pkg::ST_LOW_WT;
            clis_pkg::ST_LOW_WT:
                state_next = clis_pkg::ST_BEF_RD;
            clis_pkg::ST_BEF_RD:
                state_next = (cur_len_reg == '0) ? clis_pkg::ST_WRITE : clis_pkg::ST_BEF_WT;
            clis_pkg::ST_BEF_WT:
                state_next = clis_pkg::ST_WRITE;
            clis_pkg::ST_WRITE:
                state_next = clis_pkg::ST_DONE;
            clis_pkg::ST_DONE:
                if (out_free) state_next = clis_pkg::ST_IDLE;
            default:
                state_next = clis_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        v_next          = v_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        lvl_next        = lvl_reg;
        cur_len_next    = cur_len_reg;
        plen_next       = plen_reg;
        ways_next       = ways_reg;
        before_next     = before_reg;
        drop_next       = drop_reg;
        pile_count_next = pile_count_reg;
        top_count_next  = top_count_reg;
        ovf_next        = ovf_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_level_next  = res_level_reg;
        res_ways_next   = res_ways_reg;
        res_len_next    = res_len_reg;
        res_count_next  = res_count_reg;
        res_ovf_next    = res_ovf_reg;
        pr_we    = 1'b0;
        pr_waddr = lvl_reg[LW-1:0];
        pr_wdata = {v_reg, cur_len_reg + CW'(1)};
        pr_re    = 1'b0;
        pr_raddr = mid_w[LW-1:0];
        er_we    = 1'b0;
        er_waddr = {lvl_reg[LW-1:0], cur_len_reg[LW-1:0]};
        er_wdata = {v_reg, add_sum[NW-1:0]};
        er_re    = 1'b0;
        er_raddr = {lvl_m1[LW-1:0], mid_w[LW-1:0]};
        unique case (state_reg)
            clis_pkg::ST_IDLE:
            begin
                v_next    = item.value;
                last_next = item.last_item;
                lo_next   = '0;
                hi_next   = pile_count_reg;
                drop_next = 1'b0;
            end
            clis_pkg::ST_S1_RD:
            begin
                mid_next = mid_w;
                lvl_next = hi_reg;
                pr_re    = lo_reg < hi_reg;
            end
            clis_pkg::ST_S1_CMP:
            begin
                if (clis_pkg::s_less(pr_rdata[PW-1:CW], v_reg)) lo_next = mid_reg + CW'(1);
                else                                             hi_next = mid_reg;
            end
            clis_pkg::ST_LEN_RD:
            begin
                drop_next = lvl_reg == CW'(MAX_ITEMS);
                pr_raddr  = lvl_reg[LW-1:0];
                pr_re     = !drop_next;
            end
            clis_pkg::ST_LEN_WT:
            begin
                cur_len_next = len_now;
                drop_next    = len_now >= CW'(MAX_ITEMS);
                ways_next    = NW'(1);
                pr_raddr     = lvl_m1[LW-1:0];
                pr_re        = !drop_next && (lvl_reg != '0);
            end
            clis_pkg::ST_PLEN_WT:
            begin
                plen_next = pr_rdata[CW-1:0];
                lo_next   = '0;
                hi_next   = pr_rdata[CW-1:0];
            end
            clis_pkg::ST_S2_RD:
            begin
                mid_next = mid_w;
                er_re    = 1'b1;
                if (!(lo_reg < hi_reg))
                begin
                    // top of the previous pile holds its total
                    er_raddr = {lvl_m1[LW-1:0], LW'(plen_reg - CW'(1))};
                end
            end
            clis_pkg::ST_S2_CMP:
            begin
                if (!clis_pkg::s_less(er_rdata[EW-1:NW], v_reg)) lo_next = mid_reg + CW'(1);
                else                                              hi_next = mid_reg;
            end
            clis_pkg::ST_SUM_WT:
            begin
                ways_next = er_rdata[NW-1:0];
                er_raddr  = {lvl_m1[LW-1:0], LW'(hi_reg - CW'(1))};
                er_re     = hi_reg != '0;
            end
            clis_pkg::ST_LOW_WT:
            begin
                ways_next = ways_reg - er_rdata[NW-1:0];
            end
            clis_pkg::ST_BEF_RD:
            begin
                before_next = '0;
                er_raddr    = {lvl_reg[LW-1:0], LW'(cur_len_reg - CW'(1))};
                er_re       = cur_len_reg != '0;
            end
            clis_pkg::ST_BEF_WT:
            begin
                before_next = er_rdata[NW-1:0];
            end
            clis_pkg::ST_WRITE:
            begin
                pr_we = 1'b1;
                er_we = 1'b1;
                if (add_sum[NW]) ovf_next = 1'b1;
                if (lvl_reg + CW'(1) >= pile_count_reg) top_count_next = add_sum[NW-1:0];
                if (lvl_reg == pile_count_reg) pile_count_next = pile_count_reg + CW'(1);
            end
            clis_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_level_next = (lvl_reg == CW'(MAX_ITEMS))
                                   ? clis_pkg::LEVEL_W'(MAX_ITEMS - 1)
                                   : clis_pkg::LEVEL_W'(lvl_reg);
                    res_ways_next  = drop_reg ? '0 : ways_reg;
                    res_len_next   = clis_pkg::LENGTH_W'(pile_count_reg);
                    res_count_next = top_count_reg;
                    res_ovf_next   = ovf_reg;
                    if (last_reg)
                    begin
                        pile_count_next = '0;
                        top_count_next  = '0;
                        ovf_next        = 1'b0;
                    end
                end
            end
            default:
            begin
                drop_next = drop_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= clis_pkg::ST_IDLE;
            pile_count_reg <= '0;
            top_count_reg  <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pile_count_reg <= pile_count_next;
            top_count_reg  <= top_count_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        lvl_reg       <= lvl_next;
        cur_len_reg   <= cur_len_next;
        plen_reg      <= plen_next;
        ways_reg      <= ways_next;
        before_reg    <= before_next;
        drop_reg      <= drop_next;
        res_level_reg <= res_level_next;
        res_ways_reg  <= res_ways_next;
        res_len_reg   <= res_len_next;
        res_count_reg <= res_count_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign item.ready        = state_reg == clis_pkg::ST_IDLE;
    assign result.valid      = res_valid_reg;
    assign result.level      = res_level_reg;
    assign result.ways_here  = res_ways_reg;
    assign result.lis_length = res_len_reg;
    assign result.lis_count  = res_count_reg;
    assign result.overflow   = res_ovf_reg;

    a_pile_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pile_count_reg <= CW'(MAX_ITEMS))
        else $error("pile count beyond capacity");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (state_reg == clis_pkg::ST_S1_RD))
        else $error("accepted transaction did not start the tail search");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clis_pkg::ST_WRITE) |->
            (lvl_reg < CW'(MAX_ITEMS) && cur_len_reg < CW'(MAX_ITEMS) && !drop_reg))
        else $error("write outside storage");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pile_count_reg == '0) |-> (top_count_reg == '0 && !ovf_reg))
        else $error("counts held with no piles");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clis_pkg::ST_S1_RD || state_reg == clis_pkg::ST_S2_RD) |->
            (lo_reg <= hi_reg))
        else $error("search bounds crossed");

endmodule

`default_nettype wire

/* hw/rtl/clis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module clis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* tb/tb_count_longest_increasing_subseq_top.sv */
// Testbench for the longest increasing subsequence counter: directed and random sequences.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0]  level;
    logic [31:0] ways_here;
    logic [8:0]  lis_length;
    logic [31:0] lis_count;
    logic        overflow;
} lis_result_t;

class lis_scoreboard;
    localparam int DEPTH = 256;

    logic [31:0] tail[DEPTH];
    int unsigned pile_len[DEPTH];
    logic [31:0] entry_val[DEPTH*DEPTH];
    logic [31:0] entry_sum[DEPTH*DEPTH];
    int unsigned piles;
    bit          wrapped;
    lis_result_t pending[$];
    int          errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        foreach (pile_len[i]) pile_len[i] = 0;
        piles = 0;
        wrapped = 0;
    endfunction

    function logic [31:0] sum_upto(int unsigned p, int unsigned k);
        if (k == 0)
            return 32'd0;
        return entry_sum[p*DEPTH + k - 1];
    endfunction

    // predict the result of one accepted element
    function void note_item(logic [31:0] v, bit last_item);
        int unsigned lo, hi, mid, lvl, p, len;
        logic [31:0] ways, prev;
        logic [32:0] total;
        bit dropped;
        lis_result_t r;
        lo = 0;
        hi = piles;
        ways = 0;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if ($signed(tail[mid]) < $signed(v))
                lo = mid + 1;
            else
                hi = mid;
        end
        lvl = hi;
        dropped = (lvl >= DEPTH) || (pile_len[lvl] >= DEPTH);
        if (!dropped)
        begin
            if (lvl == 0)
                ways = 1;
            else
            begin
                p = lvl - 1;
                lo = 0;
                hi = pile_len[p];
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (!($signed(entry_val[p*DEPTH + mid]) < $signed(v)))
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                ways = sum_upto(p, pile_len[p]) - sum_upto(p, hi);
            end
            if (lvl == piles)
                piles = lvl + 1;
            tail[lvl] = v;
            len = pile_len[lvl];
            prev = sum_upto(lvl, len);
            total = {1'b0, prev} + {1'b0, ways};
            if (total[32])
                wrapped = 1;
            entry_val[lvl*DEPTH + len] = v;
            entry_sum[lvl*DEPTH + len] = total[31:0];
            pile_len[lvl] = len + 1;
        end
        else if (lvl >= DEPTH)
            lvl = DEPTH - 1;
        r.level = lvl[7:0];
        r.ways_here = ways;
        r.lis_length = piles[8:0];
        r.lis_count = (piles > 0) ? sum_upto(piles - 1, pile_len[piles - 1]) : 32'd0;
        r.overflow = wrapped;
        pending = {pending, r};
        if (last_item)
            clear();
    endfunction

    function void check_result(lis_result_t got);
        lis_result_t exp_r;
        if (pending.size() == 0)
        begin
            $error("result with no element pending");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.level !== exp_r.level)
        begin
            $error("level: expected %0d, got %0d", exp_r.level, got.level);
            errors++;
        end
        if (got.ways_here !== exp_r.ways_here)
        begin
            $error("ways_here: expected %0d, got %0d", exp_r.ways_here, got.ways_here);
            errors++;
        end
        if (got.lis_length !== exp_r.lis_length)
        begin
            $error("lis_length: expected %0d, got %0d", exp_r.lis_length, got.lis_length);
            errors++;
        end
        if (got.lis_count !== exp_r.lis_count)
        begin
            $error("lis_count: expected %0d, got %0d", exp_r.lis_count, got.lis_count);
            errors++;
        end
        if (got.overflow !== exp_r.overflow)
        begin
            $error("overflow: expected %0d, got %0d", exp_r.overflow, got.overflow);
            errors++;
        end
    endfunction
endclass

module tb_count_longest_increasing_subseq_top;
    logic clk;
    logic rst_n;
    bit   calm;
    bit   hold_done;
    int   sent;

    clis_in_if  item ();
    clis_out_if result ();

    lis_scoreboard sb;

    count_longest_increasing_subseq_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_element(logic [31:0] v, bit last_item);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.value <= v;
        item.last_item <= last_item;
        do
            @(posedge clk);
        while (!item.ready);
        sb.note_item(v, last_item);
        sent++;
    endtask

    task automatic send_run(int n, int mode);
        logic [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: v = $urandom;
                1: v = $urandom_range(0, 16) - 8;
                2: v = i * 3 + $urandom_range(0, 4) - 20;
                default: v = 1000 - i * 2 + $urandom_range(0, 3);
            endcase
            send_element(v, (i == n - 1) || ($urandom_range(0, 60) == 0));
        end
    endtask

    // result side: random back-pressure with one long hold-off
    initial
    begin
        int burst;
        result.ready = 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && sent > 60)
            begin
                hold_done = 1;
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 16);
                result.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            sb.check_result({result.level, result.ways_here, result.lis_length,
                             result.lis_count, result.overflow});
    end

    initial
    begin
        sb = new();
        calm = 0;
        sent = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.value = '0;
        item.last_item = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, duplicates, descending, end of sequence
        send_element(32'h8000_0000, 0);
        send_element(32'h7FFF_FFFF, 0);
        send_element(32'h0000_0000, 0);
        send_element(32'hFFFF_FFFF, 0);
        send_element(32'h0000_0000, 0);
        send_element(32'h0000_0001, 0);
        send_element(32'h7FFF_FFFF, 0);
        send_element(32'h8000_0000, 1);
        send_element(32'h0000_0005, 1);

        // doubling pairs push the count past 32 bits
        for (int i = 0; i < 36; i++)
        begin
            send_element(2*i + 1, 0);
            send_element(2*i, i == 35);
        end

        // more than 256 piles
        for (int i = 0; i < 258; i++)
            send_element(i - 128, i == 257);

        // one pile filled past its depth
        for (int i = 0; i < 258; i++)
            send_element(32'h0000_0007, i == 257);

        while (sent < 1450)
        begin
            if (sent > 1200)
                calm = 1;
            send_run($urandom_range(1, 40), $urandom_range(0, 3));
        end
        item.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/clis_pkg.sv
hw/rtl/clis_in_if.sv
hw/rtl/clis_out_if.sv
hw/rtl/clis_ram.sv
hw/rtl/count_longest_increasing_subseq_top.sv
tb/tb_count_longest_increasing_subseq_top.sv
